@@ sv/ctfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Clock tree frequency calculator package
// Shared payload types, register indexes and constants of the calculator.
// ----------------------------------------------------------------------------
package ctfc_pkg;

    localparam int OSC_W     = 26;
    localparam int LS_W      = 20;
    localparam int VCO_W     = 35;
    localparam int HZ_W      = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERNAL_OSC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTERNAL_OSC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LS_CRYSTAL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LS_INTERNAL  = 3'd3;

    localparam logic [1:0] SRC_INTERNAL = 2'd0;
    localparam logic [1:0] SRC_EXTERNAL = 2'd1;
    localparam logic [1:0] SRC_PLL      = 2'd2;
    localparam logic [1:0] SRC_INVALID  = 2'd3;

    localparam logic [1:0] RTC_NONE = 2'd0;
    localparam logic [1:0] RTC_LSE  = 2'd1;
    localparam logic [1:0] RTC_LSI  = 2'd2;
    localparam logic [1:0] RTC_EXT  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_ZERO_M    = 2'd2;
    localparam logic [1:0] ST_SATURATED = 2'd3;

    localparam logic [OSC_W-1:0] INTERNAL_OSC_RESET = 26'd16000000;
    localparam logic [OSC_W-1:0] EXTERNAL_OSC_RESET = 26'd8000000;
    localparam logic [LS_W-1:0]  LS_CRYSTAL_RESET   = 20'd32768;
    localparam logic [LS_W-1:0]  LS_INTERNAL_RESET  = 20'd32000;

    localparam logic [HZ_W-1:0] WS_30M  = 32'd30000000;
    localparam logic [HZ_W-1:0] WS_60M  = 32'd60000000;
    localparam logic [HZ_W-1:0] WS_90M  = 32'd90000000;
    localparam logic [HZ_W-1:0] WS_120M = 32'd120000000;
    localparam logic [HZ_W-1:0] WS_150M = 32'd150000000;
    localparam logic [HZ_W-1:0] WS_168M = 32'd168000000;
    localparam logic [HZ_W-1:0] WS_180M = 32'd180000000;

    typedef struct packed {
        logic [1:0] active_source;
        logic       pll_input_select;
        logic [5:0] pll_m;
        logic [8:0] pll_n;
        logic [1:0] pll_p_code;
        logic [3:0] pll_q;
        logic [3:0] ahb_code;
        logic [2:0] apb1_code;
        logic [2:0] apb2_code;
        logic [1:0] rtc_select;
        logic [4:0] rtc_prescale;
    } clock_in_t;

    typedef struct packed {
        logic [31:0] sysclk_hz;
        logic [31:0] hclk_hz;
        logic [31:0] apb1_hz;
        logic [31:0] apb2_hz;
        logic [31:0] pll48_hz;
        logic [31:0] rtc_hz;
        logic [2:0]  flash_wait_states;
        logic [1:0]  status;
    } clock_out_t;

    // Fields that travel alongside the divider chains.
    typedef struct packed {
        logic [1:0]       src;
        logic             m_zero;
        logic             q_zero;
        logic [8:0]       n;
        logic [3:0]       q;
        logic [1:0]       p_code;
        logic [3:0]       ahb;
        logic [2:0]       apb1;
        logic [2:0]       apb2;
        logic [1:0]       rsel;
        logic [4:0]       rpre;
        logic [OSC_W-1:0] rtc_div;
    } side_t;

endpackage

@@ sv/clock_tree_frequency_calculator.sv @@
// ----------------------------------------------------------------------------
// Clock tree frequency calculator
// Works out system, bus, PLL48 and RTC clock frequencies and flash wait states.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------------
//  in       in_valid / in_ready    in_data  (clock_in_t, one snapshot)
//  out      out_valid / out_ready  out_data (clock_out_t, one result)
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (oscillator registers)
//
//  An item passes 63 register stages: 26 divider cells for reference / M and
//  external / prescale, one multiply register for N, 35 divider cells for the
//  Q and P divisions, and the output register. The first stage is loaded at
//  the accepting edge. A new item may enter in every cycle in which the
//  pipeline is not held. Reset clears the valid line and loads the oscillator
//  registers with their reset frequencies. When a result waits untaken, the
//  pipeline stops only once an item reaches the last cell of the Q/P chains.
//
module clock_tree_frequency_calculator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ctfc_pkg::clock_in_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ctfc_pkg::clock_out_t            out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ctfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctfc_pkg::OSC_W-1:0]      cfg_data
);

    import ctfc_pkg::*;

    localparam int L1 = OSC_W;
    localparam int L2 = VCO_W;

    // Oscillator frequency registers.
    logic [OSC_W-1:0] int_osc_reg;
    logic [OSC_W-1:0] ext_osc_reg;
    logic [LS_W-1:0]  lse_reg;
    logic [LS_W-1:0]  lsi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_osc_reg <= INTERNAL_OSC_RESET;
            ext_osc_reg <= EXTERNAL_OSC_RESET;
            lse_reg     <= LS_CRYSTAL_RESET;
            lsi_reg     <= LS_INTERNAL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INTERNAL_OSC: int_osc_reg <= cfg_data;
                CFG_EXTERNAL_OSC: ext_osc_reg <= cfg_data;
                CFG_LS_CRYSTAL:   lse_reg     <= cfg_data[LS_W-1:0];
                CFG_LS_INTERNAL:  lsi_reg     <= cfg_data[LS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Pipeline advance: held only when the last stage has an item and the
    // output register is full and not being taken.
    logic       en;
    logic [L1-1:0] v1_reg;
    logic          vb_reg;
    logic [L2-1:0] v2_reg;
    logic          out_valid_reg, out_valid_next;
    logic          out_load;

    assign en       = !out_valid_reg || out_ready || !v2_reg[L2-1];
    assign in_ready = en;
    assign out_load = en && v2_reg[L2-1];

    // Entry: sideband and divider operands for the first chain.
    side_t            side_in;
    logic [OSC_W-1:0] ref_hz;

    always_comb
    begin
        ref_hz          = in_data.pll_input_select ? ext_osc_reg : int_osc_reg;
        side_in.src     = in_data.active_source;
        side_in.m_zero  = (in_data.pll_m == 6'd0);
        side_in.q_zero  = (in_data.pll_q == 4'd0);
        side_in.n       = in_data.pll_n;
        side_in.q       = in_data.pll_q;
        side_in.p_code  = in_data.pll_p_code;
        side_in.ahb     = in_data.ahb_code;
        side_in.apb1    = in_data.apb1_code;
        side_in.apb2    = in_data.apb2_code;
        side_in.rsel    = in_data.rtc_select;
        side_in.rpre    = in_data.rtc_prescale;
        side_in.rtc_div = '0;
    end

    logic [OSC_W-1:0] ref_div_m;
    logic [OSC_W-1:0] ext_div_rpre;

    ctfc_div_chain #(.DW(OSC_W), .VW(6)) u_chain_m (
        .clk     (clk),
        .en      (en),
        .dividend(ref_hz),
        .divisor (in_data.pll_m),
        .quotient(ref_div_m)
    );

    ctfc_div_chain #(.DW(OSC_W), .VW(6)) u_chain_rtc (
        .clk     (clk),
        .en      (en),
        .dividend(ext_osc_reg),
        .divisor ({1'b0, in_data.rtc_prescale}),
        .quotient(ext_div_rpre)
    );

    side_t side1_reg [0:L1-1];
    side_t sideb_reg, sideb_next;
    side_t side2_reg [0:L2-1];
    logic [VCO_W-1:0] vco_reg;

    // The RTC quotient joins the sideband as it leaves the first chain.
    always_comb
    begin
        sideb_next         = side1_reg[L1-1];
        sideb_next.rtc_div = ext_div_rpre;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg[0] <= side_in;
            for (int k = 1; k < L1; k++)
            begin
                side1_reg[k] <= side1_reg[k-1];
            end
            sideb_reg    <= sideb_next;
            vco_reg      <= VCO_W'(ref_div_m) * VCO_W'(side1_reg[L1-1].n);
            side2_reg[0] <= sideb_reg;
            for (int k = 1; k < L2; k++)
            begin
                side2_reg[k] <= side2_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= '0;
            vb_reg        <= 1'b0;
            v2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v1_reg <= {v1_reg[L1-2:0], in_valid};
                vb_reg <= v1_reg[L1-1];
                v2_reg <= {v2_reg[L2-2:0], vb_reg};
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Second chain: the VCO divided by Q and by the main divider P. A zero Q
    // gives a meaningless quotient that the last stage ignores.
    logic [2:0]       p_half;
    logic [3:0]       p_div;
    logic [VCO_W-1:0] vco_div_q;
    logic [VCO_W-1:0] vco_div_p;

    assign p_half = {1'b0, sideb_reg.p_code} + 3'd1;
    assign p_div  = {p_half, 1'b0};

    ctfc_div_chain #(.DW(VCO_W), .VW(4)) u_chain_q (
        .clk     (clk),
        .en      (en),
        .dividend(vco_reg),
        .divisor (sideb_reg.q),
        .quotient(vco_div_q)
    );

    ctfc_div_chain #(.DW(VCO_W), .VW(4)) u_chain_p (
        .clk     (clk),
        .en      (en),
        .dividend(vco_reg),
        .divisor (p_div),
        .quotient(vco_div_p)
    );

    // Final result from the last stage.
    side_t      so;
    clock_out_t res;
    clock_out_t out_reg;
    logic       sat;
    logic [3:0] ahb_shift;
    logic [2:0] s1, s2;

    always_comb
    begin
        so  = side2_reg[L2-1];
        sat = 1'b0;
        res = '0;
        case (so.src)
            SRC_INTERNAL: res.sysclk_hz = 32'(int_osc_reg);
            SRC_EXTERNAL: res.sysclk_hz = 32'(ext_osc_reg);
            SRC_PLL:
            begin
                if (!so.m_zero)
                begin
                    if (vco_div_p[VCO_W-1:HZ_W] != '0)
                    begin
                        sat           = 1'b1;
                        res.sysclk_hz = '1;
                    end
                    else
                    begin
                        res.sysclk_hz = vco_div_p[HZ_W-1:0];
                    end
                end
            end
            default: res.sysclk_hz = '0;
        endcase

        if (!so.m_zero && !so.q_zero)
        begin
            if (vco_div_q[VCO_W-1:HZ_W] != '0)
            begin
                sat          = 1'b1;
                res.pll48_hz = '1;
            end
            else
            begin
                res.pll48_hz = vco_div_q[HZ_W-1:0];
            end
        end

        if (so.src == SRC_INVALID)
            res.status = ST_INVALID;
        else if (so.src == SRC_PLL && so.m_zero)
            res.status = ST_ZERO_M;
        else if (sat)
            res.status = ST_SATURATED;
        else
            res.status = ST_OK;

        if (so.ahb < 4'd8)
            ahb_shift = 4'd0;
        else if (so.ahb < 4'd12)
            ahb_shift = so.ahb - 4'd7;
        else
            ahb_shift = so.ahb - 4'd6;
        s1 = (so.apb1 > 3'd3) ? so.apb1 - 3'd3 : 3'd0;
        s2 = (so.apb2 > 3'd3) ? so.apb2 - 3'd3 : 3'd0;
        res.hclk_hz = res.sysclk_hz >> ahb_shift;
        res.apb1_hz = res.hclk_hz >> s1;
        res.apb2_hz = res.hclk_hz >> s2;

        case (so.rsel)
            RTC_LSE: res.rtc_hz = 32'(lse_reg);
            RTC_LSI: res.rtc_hz = 32'(lsi_reg);
            RTC_EXT: res.rtc_hz = (so.rpre >= 5'd2) ? 32'(so.rtc_div) : 32'(ext_osc_reg);
            default: res.rtc_hz = '0;
        endcase

        if (res.sysclk_hz <= WS_30M)
            res.flash_wait_states = 3'd0;
        else if (res.sysclk_hz <= WS_60M)
            res.flash_wait_states = 3'd1;
        else if (res.sysclk_hz <= WS_90M)
            res.flash_wait_states = 3'd2;
        else if (res.sysclk_hz <= WS_120M)
            res.flash_wait_states = 3'd3;
        else if (res.sysclk_hz <= WS_150M)
            res.flash_wait_states = 3'd4;
        else if (res.sysclk_hz <= WS_168M)
            res.flash_wait_states = 3'd5;
        else if (res.sysclk_hz <= WS_180M)
            res.flash_wait_states = 3'd6;
        else
            res.flash_wait_states = 3'd7;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The input side stalls only behind a result that is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a held result");

    // An invalid source never reports a system clock frequency.
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_INVALID) |-> (out_data.sysclk_hz == '0))
        else $error("invalid source with non-zero system clock");

    // The AHB clock never exceeds the system clock, nor the APB1 clock the AHB clock.
    a_bus_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.hclk_hz <= out_data.sysclk_hz
                       && out_data.apb1_hz <= out_data.hclk_hz))
        else $error("bus clock above its parent clock");

endmodule

@@ sv/ctfc_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: takes one dividend bit, yields one quotient bit.
// ----------------------------------------------------------------------------
module ctfc_div_cell #(
    parameter int DW = 26,
    parameter int VW = 6
) (
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] rem_in,
    input  logic [DW-1:0] word_in,
    input  logic [VW-1:0] div_in,
    output logic [VW-1:0] rem_out,
    output logic [DW-1:0] word_out,
    output logic [VW-1:0] div_out
);

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] word_reg, word_next;
    logic [VW-1:0] div_reg;

    // The word holds the unused dividend bits above and quotient bits below.
    always_comb
    begin
        trial     = {rem_in, word_in[DW-1]};
        diff      = trial - {1'b0, div_in};
        ge        = (trial >= {1'b0, div_in});
        rem_next  = ge ? diff[VW-1:0] : trial[VW-1:0];
        word_next = {word_in[DW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            word_reg <= word_next;
            div_reg  <= div_in;
        end
    end

    assign rem_out  = rem_reg;
    assign word_out = word_reg;
    assign div_out  = div_reg;

endmodule

@@ sv/ctfc_div_chain.sv @@
// ----------------------------------------------------------------------------
// Divider chain
// One divider cell per dividend bit; one quotient a cycle while en is high.
// ----------------------------------------------------------------------------
module ctfc_div_chain #(
    parameter int DW = 26,
    parameter int VW = 6
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient
);

    logic [VW-1:0] rem_w  [0:DW];
    logic [DW-1:0] word_w [0:DW];
    logic [VW-1:0] div_w  [0:DW];

    assign rem_w[0]  = '0;
    assign word_w[0] = dividend;
    assign div_w[0]  = divisor;

    for (genvar k = 0; k < DW; k++)
    begin : g_cell
        ctfc_div_cell #(
            .DW(DW),
            .VW(VW)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .rem_in  (rem_w[k]),
            .word_in (word_w[k]),
            .div_in  (div_w[k]),
            .rem_out (rem_w[k+1]),
            .word_out(word_w[k+1]),
            .div_out (div_w[k+1])
        );
    end

    assign quotient = word_w[DW];

endmodule
